// File: rtl/core/heading_rate_pid_servo_drive_assert.svh
// assertion macros for the heading rate pid servo drive
// included by the top level, no other dependencies
`ifndef HEADING_RATE_PID_SERVO_DRIVE_ASSERT_SVH
`define HEADING_RATE_PID_SERVO_DRIVE_ASSERT_SVH

// same cycle implication
`define HRPSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrpsd assertion failed");

// next cycle implication
`define HRPSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrpsd assertion failed");

`endif

// File: rtl/core/hrpsd_pkg.sv
// shared widths, constants, register indexes and result structs
// used by hrpsd_mul, hrpsd_div and heading_rate_pid_servo_drive
package hrpsd_pkg;

  localparam int GAIN_W     = 24;
  localparam int PER_W      = 10;
  localparam int HEAD_W     = 13;
  localparam int THR_W      = 12;
  localparam int TIME_W     = 32;
  localparam int PWM_W      = 12;
  localparam int CORR_W     = 11;
  localparam int STEP_W     = 14;
  localparam int OPND_W     = STEP_W + 1;
  localparam int PROD_W     = GAIN_W + OPND_W;
  localparam int MUL_CNT_W  = $clog2(OPND_W);
  localparam int DIV_CNT_W  = $clog2(PROD_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int WRAP_LIMIT = 60 * 16;
  localparam int FULL_TURN  = 360 * 16;
  localparam int PWM_MAX    = 4095;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GATE    = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST     = 24'd367002;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST    = 24'd524;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST    = 24'd2097152;
  localparam logic [PER_W-1:0]  UPDATE_PERIOD_RST = 10'd40;
  localparam logic [PER_W-1:0]  DRIVE_LIMIT_RST   = 10'd80;
  localparam logic [PER_W-1:0]  INTEG_GATE_RST    = 10'd16;

  typedef struct packed {
    logic              done;
    logic              neg;
    logic [PROD_W-1:0] mag;
  } mul_res_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_res_t;

endpackage

// File: rtl/core/heading_rate_pid_servo_drive.sv
// top level of the heading rate pid servo drive: config registers, sequencer, output stage
// depends on hrpsd_pkg, hrpsd_mul, hrpsd_div and heading_rate_pid_servo_drive_assert.svh
// Each input transaction yields exactly one output transaction. The block works on one
// sample at a time: a sample that does not trigger a controller update goes from
// ST_STEP straight to ST_FINISH, and a sample that does passes through three runs of the
// bit-serial multiplier (one operand bit per cycle) and the restoring divider for the
// derivative term (one quotient bit per cycle), then ST_CORR and ST_CLAMP. A finished
// result waits in the output register while the next sample is accepted.
// Configuration registers may be written only while no sample is in flight.
`include "heading_rate_pid_servo_drive_assert.svh"

module heading_rate_pid_servo_drive #(
  parameter int GAIN_FRAC_BITS = 20,
  parameter int INTEG_WIDTH    = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [hrpsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hrpsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [hrpsd_pkg::HEAD_W-1:0]          heading,
  input  logic [hrpsd_pkg::THR_W-1:0]           throttle,
  input  logic [hrpsd_pkg::TIME_W-1:0]          time_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hrpsd_pkg::PWM_W-1:0]           pwm_out,
  output logic                                  updated,
  output logic signed [hrpsd_pkg::CORR_W-1:0]   correction,
  output logic signed [hrpsd_pkg::STEP_W-1:0]   heading_step
);

  localparam int GAIN_W = hrpsd_pkg::GAIN_W;
  localparam int PER_W  = hrpsd_pkg::PER_W;
  localparam int HEAD_W = hrpsd_pkg::HEAD_W;
  localparam int THR_W  = hrpsd_pkg::THR_W;
  localparam int TIME_W = hrpsd_pkg::TIME_W;
  localparam int PWM_W  = hrpsd_pkg::PWM_W;
  localparam int CORR_W = hrpsd_pkg::CORR_W;
  localparam int STEP_W = hrpsd_pkg::STEP_W;
  localparam int OPND_W = hrpsd_pkg::OPND_W;
  localparam int PROD_W = hrpsd_pkg::PROD_W;
  localparam int IW     = INTEG_WIDTH;
  localparam int FRAC   = GAIN_FRAC_BITS;
  localparam int IA_W   = ((IW > PROD_W + 1) ? IW : PROD_W + 1) + 1;
  localparam int SUM_W  = IA_W + 1;
  localparam int CW     = SUM_W - FRAC;

  localparam logic signed [STEP_W:0] WRAP_HI = (STEP_W + 1)'(hrpsd_pkg::WRAP_LIMIT);
  localparam logic signed [STEP_W:0] WRAP_LO = -WRAP_HI;
  localparam logic signed [STEP_W:0] TURN    = (STEP_W + 1)'(hrpsd_pkg::FULL_TURN);
  localparam logic signed [PWM_W+1:0] PWM_TOP = (PWM_W + 2)'(hrpsd_pkg::PWM_MAX);
  localparam logic signed [IA_W-1:0] INTEG_HI = {{(IA_W - IW + 1){1'b0}}, {(IW - 1){1'b1}}};
  localparam logic signed [IA_W-1:0] INTEG_LO = {{(IA_W - IW + 1){1'b1}}, {(IW - 1){1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_STEP   = 9'b000000010,
    ST_MUL_P  = 9'b000000100,
    ST_MUL_I  = 9'b000001000,
    ST_MUL_D  = 9'b000010000,
    ST_DIV_D  = 9'b000100000,
    ST_CORR   = 9'b001000000,
    ST_CLAMP  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [GAIN_W-1:0] gain_prop;
  logic [GAIN_W-1:0] gain_integ;
  logic [GAIN_W-1:0] gain_deriv;
  logic [PER_W-1:0]  update_period;
  logic [PER_W-1:0]  drive_limit;
  logic [PER_W-1:0]  integ_gate;

  // controller state
  logic [HEAD_W-1:0]        last_heading;
  logic signed [STEP_W-1:0] last_step;
  logic signed [IW-1:0]     integ_sum;
  logic [TIME_W-1:0]        last_update_time;
  logic signed [CORR_W-1:0] held_corr;

  // sample and working registers
  logic [HEAD_W-1:0]        head_r;
  logic [THR_W-1:0]         thr_r;
  logic [TIME_W-1:0]        time_r;
  logic signed [STEP_W-1:0] step_r;
  logic                     upd_r;
  logic signed [PROD_W:0]   p_r;
  logic                     d_neg;
  logic signed [SUM_W-1:0]  pi_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [CW-1:0]     corr_r;

  // combinational
  logic signed [STEP_W:0]   diff_c;
  logic signed [STEP_W:0]   wrap_c;
  logic signed [STEP_W-1:0] step_c;
  logic [PER_W-1:0]         per_eff;
  logic [TIME_W-1:0]        elapsed;
  logic                     upd_c;
  logic [STEP_W-1:0]        step_mag;
  logic                     gate_c;
  logic signed [OPND_W-1:0] dstep_c;
  logic signed [PROD_W:0]   prod_s;
  logic signed [PROD_W:0]   quot_s;
  logic signed [IA_W-1:0]   integ_add;
  logic signed [IA_W-1:0]   integ_sat;
  logic signed [SUM_W-1:0]  pi_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  sum_b;
  logic signed [CW-1:0]     lim_c;
  logic signed [CW-1:0]     clamp_c;
  logic signed [PWM_W+1:0]  pwm_s;
  logic [PWM_W-1:0]         pwm_c;
  logic signed [PER_W:0]    lim_s;
  logic                     out_load;
  logic                     held_ok;
  logic                     in_mul;

  // serial units
  logic                     mul_start;
  logic [GAIN_W-1:0]        mul_gain;
  logic signed [OPND_W-1:0] mul_opnd;
  hrpsd_pkg::mul_res_t      mul_res;
  logic                     div_start;
  hrpsd_pkg::div_res_t      div_res;

  hrpsd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .gain  (mul_gain),
    .opnd  (mul_opnd),
    .res   (mul_res)
  );

  hrpsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_res.mag),
    .divisor  (per_eff),
    .res      (div_res)
  );

  // heading step with wrap
  assign diff_c = $signed({{(STEP_W + 1 - HEAD_W){1'b0}}, head_r})
                - $signed({{(STEP_W + 1 - HEAD_W){1'b0}}, last_heading});

  always_comb begin
    if (diff_c < WRAP_LO) begin
      wrap_c = diff_c + TURN;
    end else if (diff_c > WRAP_HI) begin
      wrap_c = diff_c - TURN;
    end else begin
      wrap_c = diff_c;
    end
  end

  assign step_c  = wrap_c[STEP_W-1:0];
  assign per_eff = (update_period == '0) ? PER_W'(1) : update_period;
  assign elapsed = time_r - last_update_time;
  assign upd_c   = elapsed > {{(TIME_W - PER_W){1'b0}}, per_eff};

  assign step_mag = step_r[STEP_W-1] ? $unsigned(-step_r) : $unsigned(step_r);
  assign gate_c   = step_mag < {{(STEP_W - PER_W){1'b0}}, integ_gate};
  assign dstep_c  = {step_r[STEP_W-1], step_r} - {last_step[STEP_W-1], last_step};

  assign prod_s = mul_res.neg ? -$signed({1'b0, mul_res.mag}) : $signed({1'b0, mul_res.mag});
  assign quot_s = d_neg ? -$signed({1'b0, div_res.quot}) : $signed({1'b0, div_res.quot});

  // integral with saturation
  assign integ_add = {{(IA_W - IW){integ_sum[IW-1]}}, integ_sum}
                   + {{(IA_W - PROD_W - 1){prod_s[PROD_W]}}, prod_s};

  always_comb begin
    if (integ_add > INTEG_HI) begin
      integ_sat = INTEG_HI;
    end else if (integ_add < INTEG_LO) begin
      integ_sat = INTEG_LO;
    end else begin
      integ_sat = integ_add;
    end
  end

  assign pi_c  = {{(SUM_W - PROD_W - 1){p_r[PROD_W]}}, p_r}
               + {{(SUM_W - IW){integ_sum[IW-1]}}, integ_sum};
  assign sum_c = pi_r + {{(SUM_W - PROD_W - 1){quot_s[PROD_W]}}, quot_s};

  // truncate toward zero
  assign sum_b = sum_r + (sum_r[SUM_W-1] ? {{(SUM_W - FRAC){1'b0}}, {FRAC{1'b1}}} : '0);

  assign lim_c = $signed({{(CW - PER_W){1'b0}}, drive_limit});

  always_comb begin
    if (corr_r > lim_c) begin
      clamp_c = lim_c;
    end else if (corr_r < -lim_c) begin
      clamp_c = -lim_c;
    end else begin
      clamp_c = corr_r;
    end
  end

  assign pwm_s = $signed({2'b00, thr_r}) + {{3{held_corr[CORR_W-1]}}, held_corr};

  always_comb begin
    if (pwm_s[PWM_W+1]) begin
      pwm_c = '0;
    end else if (pwm_s > PWM_TOP) begin
      pwm_c = PWM_TOP[PWM_W-1:0];
    end else begin
      pwm_c = pwm_s[PWM_W-1:0];
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);
  assign lim_s    = $signed({1'b0, drive_limit});
  assign held_ok  = (held_corr <= lim_s) && (held_corr >= -lim_s);
  assign in_mul   = (state == ST_MUL_P) || (state == ST_MUL_I) || (state == ST_MUL_D);

  // sequencer
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_gain   = gain_prop;
    mul_opnd   = {step_c[STEP_W-1], step_c};
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (upd_c) begin
          mul_start  = 1'b1;
          state_next = ST_MUL_P;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MUL_P: begin
        mul_gain = gain_integ;
        mul_opnd = {step_r[STEP_W-1], step_r};
        if (mul_res.done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        mul_gain = gain_deriv;
        mul_opnd = dstep_c;
        if (mul_res.done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        if (mul_res.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (div_res.done) begin
          state_next = ST_CORR;
        end
      end
      ST_CORR: begin
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= hrpsd_pkg::GAIN_PROP_RST;
      gain_integ    <= hrpsd_pkg::GAIN_INTEG_RST;
      gain_deriv    <= hrpsd_pkg::GAIN_DERIV_RST;
      update_period <= hrpsd_pkg::UPDATE_PERIOD_RST;
      drive_limit   <= hrpsd_pkg::DRIVE_LIMIT_RST;
      integ_gate    <= hrpsd_pkg::INTEG_GATE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        hrpsd_pkg::CFG_GAIN_PROP:     gain_prop     <= cfg_data;
        hrpsd_pkg::CFG_GAIN_INTEG:    gain_integ    <= cfg_data;
        hrpsd_pkg::CFG_GAIN_DERIV:    gain_deriv    <= cfg_data;
        hrpsd_pkg::CFG_UPDATE_PERIOD: update_period <= cfg_data[PER_W-1:0];
        hrpsd_pkg::CFG_DRIVE_LIMIT:   drive_limit   <= cfg_data[PER_W-1:0];
        hrpsd_pkg::CFG_INTEG_GATE:    integ_gate    <= cfg_data[PER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // datapath and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      last_heading     <= '0;
      last_step        <= '0;
      integ_sum        <= '0;
      last_update_time <= '0;
      held_corr        <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        head_r <= heading;
        thr_r  <= throttle;
        time_r <= time_ms;
      end
      if (state == ST_STEP) begin
        step_r       <= step_c;
        upd_r        <= upd_c;
        last_heading <= head_r;
        if (upd_c) begin
          last_update_time <= time_r;
        end
      end
      if ((state == ST_MUL_P) && mul_res.done) begin
        p_r <= prod_s;
      end
      if ((state == ST_MUL_I) && mul_res.done && gate_c) begin
        integ_sum <= integ_sat[IW-1:0];
      end
      if (state == ST_MUL_D) begin
        pi_r <= pi_c;
        if (mul_res.done) begin
          d_neg <= mul_res.neg;
        end
      end
      if ((state == ST_DIV_D) && div_res.done) begin
        sum_r <= sum_c;
      end
      if (state == ST_CORR) begin
        corr_r <= sum_b[SUM_W-1:FRAC];
      end
      if (state == ST_CLAMP) begin
        held_corr <= clamp_c[CORR_W-1:0];
      end
      if (out_load) begin
        out_valid    <= 1'b1;
        last_step    <= step_r;
        pwm_out      <= pwm_c;
        updated      <= upd_r;
        correction   <= held_corr;
        heading_step <= step_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HRPSD_ASSERT_IMP(a_held_in_limit, clk, rst, (state == ST_FINISH) && upd_r, held_ok)
  `HRPSD_ASSERT_IMP(a_mul_done_in_mul, clk, rst, mul_res.done, in_mul)
  `HRPSD_ASSERT_NXT(a_accept_to_step, clk, rst, in_valid && in_ready, state == ST_STEP)
  `HRPSD_ASSERT_NXT(a_no_update_skip, clk, rst, (state == ST_STEP) && !upd_c, state == ST_FINISH)

endmodule

// File: rtl/core/hrpsd_mul.sv
// bit-serial shift-add multiplier, unsigned gain times signed operand
// one operand bit per cycle; depends on hrpsd_pkg
module hrpsd_mul (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [hrpsd_pkg::GAIN_W-1:0]              gain,
  input  logic signed [hrpsd_pkg::OPND_W-1:0]       opnd,
  output hrpsd_pkg::mul_res_t                       res
);

  localparam int GAIN_W    = hrpsd_pkg::GAIN_W;
  localparam int OPND_W    = hrpsd_pkg::OPND_W;
  localparam int MUL_CNT_W = hrpsd_pkg::MUL_CNT_W;

  logic                 busy;
  logic                 done;
  logic                 neg;
  logic [GAIN_W-1:0]    gain_r;
  logic [GAIN_W-1:0]    acc;
  logic [OPND_W-1:0]    mq;
  logic [MUL_CNT_W-1:0] cnt;
  logic [OPND_W-1:0]    opnd_mag;
  logic [GAIN_W:0]      psum;

  assign opnd_mag = opnd[OPND_W-1] ? $unsigned(-opnd) : $unsigned(opnd);
  assign psum     = {1'b0, acc} + (mq[0] ? {1'b0, gain_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mq     <= opnd_mag;
        gain_r <= gain;
        neg    <= opnd[OPND_W-1];
      end else if (busy) begin
        acc <= psum[GAIN_W:1];
        mq  <= {psum[0], mq[OPND_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(OPND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.neg  = neg;
  assign res.mag  = {acc, mq};

endmodule

// File: rtl/core/hrpsd_div.sv
// restoring divider, one quotient bit per cycle
// product magnitude over the update period; depends on hrpsd_pkg
module hrpsd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hrpsd_pkg::PROD_W-1:0]  dividend,
  input  logic [hrpsd_pkg::PER_W-1:0]   divisor,
  output hrpsd_pkg::div_res_t           res
);

  localparam int PROD_W    = hrpsd_pkg::PROD_W;
  localparam int PER_W     = hrpsd_pkg::PER_W;
  localparam int DIV_CNT_W = hrpsd_pkg::DIV_CNT_W;

  logic                 busy;
  logic                 done;
  logic [PROD_W-1:0]    q;
  logic [PER_W-1:0]     rem;
  logic [PER_W-1:0]     divisor_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PER_W:0]       rem_sh;
  logic [PER_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, q[PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_r};
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        q         <= dividend;
        rem       <= '0;
        divisor_r <= divisor;
      end else if (busy) begin
        rem <= ge ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
        q   <= {q[PROD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = q;

endmodule
